// File: rtl/core/ecfp_pkg.sv
package ecfp_pkg;

	// Frame bytes
	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] ESC_BOTH   = 8'h03;
	localparam logic [7:0] ESC_UPPER  = 8'h02;
	localparam logic [7:0] ESC_LOWER  = 8'h01;

	// Command queue depth
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_DIR   = 3'd1,
		PH_UPPER = 3'd2,
		PH_LOWER = 3'd3,
		PH_ESC   = 3'd4
	} phase_t;

	// Raw command as captured by the front end; escape applied in the back end
	typedef struct packed {
		logic       clockwise;
		logic [7:0] upper;
		logic [7:0] lower;
		logic [7:0] esc;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: rtl/core/ecfp_front.sv
module ecfp_front
	import ecfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] rx_byte,
	input  logic      in_valid,
	output logic      in_ready,
	input  q_status_t q_status,
	output logic      push,
	output cmd_t      push_cmd
);

	phase_t     phase_q;
	phase_t     phase_nxt;
	logic       dir_q;
	logic [7:0] upper_q;
	logic [7:0] lower_q;
	logic       accept;

	// Only the escape word needs queue space
	assign in_ready = !(phase_q == PH_ESC && q_status.full);
	assign accept   = in_valid && in_ready;
	assign push     = accept && (phase_q == PH_ESC);

	assign push_cmd.clockwise = dir_q;
	assign push_cmd.upper     = upper_q;
	assign push_cmd.lower     = lower_q;
	assign push_cmd.esc       = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		if (accept) begin
			case (phase_q)
				PH_DIR:   phase_nxt = PH_UPPER;
				PH_UPPER: phase_nxt = PH_LOWER;
				PH_LOWER: phase_nxt = PH_ESC;
				PH_ESC:   phase_nxt = PH_HUNT;
				default:  phase_nxt = (rx_byte == START_BYTE) ? PH_DIR : PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_DIR) begin
			dir_q <= (rx_byte != 8'd0);
		end
		if (accept && phase_q == PH_UPPER) begin
			upper_q <= rx_byte;
		end
		if (accept && phase_q == PH_LOWER) begin
			lower_q <= rx_byte;
		end
	end

endmodule

// File: rtl/core/ecfp_queue.sv
module ecfp_queue
	import ecfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t status
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/core/ecfp_back.sv
module ecfp_back
	import ecfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  q_status_t  q_status,
	input  cmd_t       head,
	output logic       pop,
	output logic       clockwise,
	output logic [15:0] duty_value,
	output logic       out_valid,
	input  logic       out_ready
);

	logic        valid_q;
	logic        cw_q;
	logic [15:0] duty_q;
	logic [7:0]  hi;
	logic [7:0]  lo;

	// Load output register when empty or being drained
	assign pop = !q_status.empty && (!valid_q || out_ready);

	always_comb begin
		hi = head.upper;
		lo = head.lower;
		case (head.esc)
			ESC_BOTH: begin
				hi = 8'hFF;
				lo = 8'hFF;
			end
			ESC_UPPER: hi = 8'hFF;
			ESC_LOWER: lo = 8'hFF;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cw_q   <= head.clockwise;
			duty_q <= {hi, lo};
		end
	end

	assign out_valid  = valid_q;
	assign clockwise  = cw_q;
	assign duty_value = duty_q;

endmodule

// File: rtl/core/escaped_command_frame_parser.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   rx_byte[7:0]
// out      output     out_valid / out_ready clockwise, duty_value[15:0]
//
// One word per cycle on the input while in_ready is high; a frame of five words gives one result.
// The escape word's result passes through the queue, then the output register, which drives out_valid.
// arst_n clears the phase to hunting, empties the queue and drops out_valid.
// in_ready falls only on an escape word with the two-entry command queue full;
// all other words are taken regardless of output stalls.
module escaped_command_frame_parser
	import ecfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        clockwise,
	output logic [15:0] duty_value,
	output logic        out_valid,
	input  logic        out_ready
);

	// Front end: hunts for the start word and latches direction and data words
	q_status_t q_status;
	logic      push;
	cmd_t      push_cmd;
	// Back end: applies the escape mask and holds the result
	logic      pop;
	cmd_t      head;

	ecfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Short command queue decouples the frame parser from output stalls
	ecfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	ecfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.head       (head),
		.pop        (pop),
		.clockwise  (clockwise),
		.duty_value (duty_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

// File: sim/duty_command_checker.sv
`timescale 1ns / 100ps

// Watches both channels, tracks the frame phase and predicts one command per frame
module duty_command_checker
	import ecfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        clockwise,
	input  logic [15:0] duty_value,
	input  logic        out_valid,
	input  logic        out_ready,
	output int          mismatch_count,
	output int          awaiting,
	output int          checked
);

	typedef struct packed {
		logic        cw;
		logic [15:0] duty;
	} duty_cmd_t;

	duty_cmd_t  expected_cmds[$];
	phase_t     phase;
	logic       dir_hold;
	logic [7:0] upper_hold;
	logic [7:0] lower_hold;

	task automatic note_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : model
		duty_cmd_t  want;
		logic [7:0] hi;
		logic [7:0] lo;
		if (!arst_n) begin
			phase = PH_HUNT;
			dir_hold = 1'b0;
			upper_hold = '0;
			lower_hold = '0;
			expected_cmds.delete();
			mismatch_count = 0;
			checked = 0;
			awaiting = 0;
		end else begin
			// output side first; a result can never leave on the edge its frame ends
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					note_mismatch("unexpected result", '0, duty_value);
				end else begin
					want = expected_cmds.pop_front();
					checked++;
					if (clockwise !== want.cw)
						note_mismatch("clockwise", {15'd0, want.cw}, {15'd0, clockwise});
					if (duty_value !== want.duty)
						note_mismatch("duty_value", want.duty, duty_value);
				end
			end
			if (in_valid && in_ready) begin
				case (phase)
					PH_DIR: begin
						dir_hold = (rx_byte != '0);
						phase = PH_UPPER;
					end
					PH_UPPER: begin
						upper_hold = rx_byte;
						phase = PH_LOWER;
					end
					PH_LOWER: begin
						lower_hold = rx_byte;
						phase = PH_ESC;
					end
					PH_ESC: begin
						hi = upper_hold;
						lo = lower_hold;
						if (rx_byte == ESC_BOTH) begin
							hi = '1;
							lo = '1;
						end else if (rx_byte == ESC_UPPER) begin
							hi = '1;
						end else if (rx_byte == ESC_LOWER) begin
							lo = '1;
						end
						expected_cmds.push_back({dir_hold, hi, lo});
						phase = PH_HUNT;
					end
					default: begin
						// hunting: only the start word opens a frame
						phase = (rx_byte == START_BYTE) ? PH_DIR : PH_HUNT;
					end
				endcase
			end
			awaiting = expected_cmds.size();
		end
	end

endmodule

// File: sim/escaped_command_frame_parser_tb.sv
`timescale 1ns / 100ps

module escaped_command_frame_parser_tb
	import ecfp_pkg::*;
;

	logic        clk = 1'b0;
	logic        arst_n;
	logic [7:0]  rx_byte;
	logic        in_valid;
	logic        in_ready;
	logic        clockwise;
	logic [15:0] duty_value;
	logic        out_valid;
	logic        out_ready;

	int fail_count;
	int pending;
	int checked;

	// when set, neither side inserts idle cycles
	bit steady;
	int frame_words;
	int noise_words;

	always #6 clk = ~clk;

	escaped_command_frame_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.clockwise  (clockwise),
		.duty_value (duty_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

	duty_command_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx_byte),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.clockwise      (clockwise),
		.duty_value     (duty_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.mismatch_count (fail_count),
		.awaiting       (pending),
		.checked        (checked)
	);

	// Offer one word, after a random idle gap, and hold it until taken.
	// Returns in the time step of the accepting edge, so the next call
	// replaces valid/data with a single assignment each.
	task automatic send_word(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Start word, direction, upper, lower, escape
	task automatic send_frame(input logic [7:0] dir, input logic [7:0] upper,
			input logic [7:0] lower, input logic [7:0] esc);
		send_word(START_BYTE);
		send_word(dir);
		send_word(upper);
		send_word(lower);
		send_word(esc);
		frame_words += 5;
	endtask

	// Stop offering and wait for every predicted command to come out.
	// Polled on the falling edge so the checker's update has settled.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Receiver: random stall before each result, sometimes none at all
	initial begin : receiver
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		logic [7:0] dir;
		logic [7:0] upper;
		logic [7:0] lower;
		logic [7:0] esc;
		int n;
		arst_n      = 1'b0;
		rx_byte     = '0;
		in_valid    = 1'b0;
		out_ready   = 1'b0;
		steady      = 1'b0;
		frame_words = 0;
		noise_words = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a stray word while hunting, then frames covering each escape rule
		send_word(8'hFE);
		noise_words++;
		// counter-clockwise, all-zero data, plain escape
		send_frame(8'h00, 8'h00, 8'h00, 8'h00);
		// start word taken as direction, data and escape inside a frame
		send_frame(START_BYTE, START_BYTE, START_BYTE, START_BYTE);
		send_frame(8'h01, 8'h12, 8'h34, ESC_BOTH);
		send_frame(8'h80, 8'h12, 8'h34, ESC_UPPER);
		send_frame(8'h00, 8'h12, 8'h34, ESC_LOWER);

		// hold off until the queue is empty before going random
		drain_results();

		// Random: mostly well-formed frames, some noise that may open a truncated
		// frame and misalign the next one, bursts with no idling, occasional drains
		while (frame_words < 400) begin
			case ($urandom_range(0, 9))
				7: begin
					n = $urandom_range(1, 4);
					repeat (n) begin
						send_word(8'($urandom_range(0, 255)));
						noise_words++;
					end
				end
				8: steady = ~steady;
				9: drain_results();
				default: begin
					dir   = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
					upper = ($urandom_range(0, 5) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
					lower = ($urandom_range(0, 5) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
					case ($urandom_range(0, 5))
						0: esc = ESC_BOTH;
						1: esc = ESC_UPPER;
						2: esc = ESC_LOWER;
						3: esc = START_BYTE;
						default: esc = 8'($urandom_range(0, 255));
					endcase
					send_frame(dir, upper, lower, esc);
				end
			endcase
		end

		drain_results();
		// wait on past the drain to catch stray results
		repeat (6) @(posedge clk);

		$display("Sent %0d frame words and %0d noise words; %0d commands checked.",
			frame_words, noise_words, checked);
		if (fail_count == 0 && pending == 0) begin
			$display("[escaped_command_frame_parser] OK");
		end else begin
			$display("[escaped_command_frame_parser] ERROR");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("Timed out with %0d commands still awaited.", pending);
		$display("[escaped_command_frame_parser] ERROR");
		$finish;
	end

endmodule

// File: escaped_command_frame_parser.f
rtl/core/ecfp_pkg.sv
rtl/core/ecfp_front.sv
rtl/core/ecfp_queue.sv
rtl/core/ecfp_back.sv
rtl/core/escaped_command_frame_parser.sv
sim/duty_command_checker.sv
sim/escaped_command_frame_parser_tb.sv
